// ----- design/sacf_pkg.sv -----
package sacf_pkg;

  localparam int PC_W    = 7;
  localparam int VAL_W   = 14;
  localparam int DIG_N   = 4;
  localparam int CFG_W   = 14;
  localparam int CFG_IDX_W = 2;

  typedef logic [PC_W-1:0]  pc_t;
  typedef logic [VAL_W-1:0] val_t;

  // command selector codes
  localparam logic [2:0] CMD_POS  = 3'd0;
  localparam logic [2:0] CMD_REL  = 3'd1;
  localparam logic [2:0] CMD_ENA  = 3'd2;
  localparam logic [2:0] CMD_CEN  = 3'd3;
  localparam logic [2:0] CMD_MODE = 3'd4;
  localparam logic [2:0] CMD_FID  = 3'd5;
  localparam logic [2:0] CMD_BOOT = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION    = 2'd2;

  localparam val_t PULSE_MIN_RST = 14'd500;
  localparam val_t PULSE_MAX_RST = 14'd2500;
  localparam val_t DEC4_MAX      = 14'd9999;
  localparam logic [7:0] ADDR_MAX = 8'd254;
  localparam logic [7:0] ADDR_BCAST = 8'd255;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_DIGIT,
    OP_LOAD,
    OP_CONV,
    OP_BRANCH,
    OP_DISP
  } op_t;

  typedef enum logic [2:0] {
    SRC_ID,
    SRC_PW,
    SRC_TM,
    SRC_MODE8,
    SRC_MODE3,
    SRC_NADDR
  } src_t;

  typedef enum logic {
    C_NOFIRST,
    C_NOGRP
  } cond_t;

  typedef enum logic [1:0] {
    FIN_NO,
    FIN_YES,
    FIN_GRP
  } fin_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] chr;
    src_t       src;
    cond_t      cond;
    fin_t       fin;
    logic       jmp;
    pc_t        tgt;
  } uword_t;

  typedef struct packed {
    logic load;
    logic step;
    logic shift;
  } dig_ctl_t;

  // program labels
  localparam pc_t A_POS       = 7'd12;
  localparam pc_t A_REL       = 7'd31;
  localparam pc_t A_ENA       = 7'd34;
  localparam pc_t A_CEN       = 7'd37;
  localparam pc_t A_MOD       = 7'd40;
  localparam pc_t A_FID       = 7'd46;
  localparam pc_t A_BOOT      = 7'd55;
  localparam pc_t A_BANG_CRLF = 7'd61;
  localparam pc_t A_CRLF      = 7'd62;
  localparam pc_t A_BANG_GRP  = 7'd64;

  function automatic uword_t u_mk(op_t op, logic [7:0] c, src_t s, cond_t cd, fin_t f,
                                  logic j, pc_t t);
    uword_t w;
    w.op   = op;
    w.chr  = c;
    w.src  = s;
    w.cond = cd;
    w.fin  = f;
    w.jmp  = j;
    w.tgt  = t;
    return w;
  endfunction

  function automatic uword_t u_chr(logic [7:0] c);
    return u_mk(OP_CHAR, c, SRC_ID, C_NOFIRST, FIN_NO, 1'b0, '0);
  endfunction

  function automatic uword_t u_chrj(logic [7:0] c, pc_t t);
    return u_mk(OP_CHAR, c, SRC_ID, C_NOFIRST, FIN_NO, 1'b1, t);
  endfunction

  function automatic uword_t u_chrf(logic [7:0] c, fin_t f);
    return u_mk(OP_CHAR, c, SRC_ID, C_NOFIRST, f, 1'b0, '0);
  endfunction

  function automatic uword_t u_dig();
    return u_mk(OP_DIGIT, 8'h00, SRC_ID, C_NOFIRST, FIN_NO, 1'b0, '0);
  endfunction

  function automatic uword_t u_digj(pc_t t);
    return u_mk(OP_DIGIT, 8'h00, SRC_ID, C_NOFIRST, FIN_NO, 1'b1, t);
  endfunction

  function automatic uword_t u_load(src_t s);
    return u_mk(OP_LOAD, 8'h00, s, C_NOFIRST, FIN_NO, 1'b0, '0);
  endfunction

  function automatic uword_t u_conv();
    return u_mk(OP_CONV, 8'h00, SRC_ID, C_NOFIRST, FIN_NO, 1'b0, '0);
  endfunction

  function automatic uword_t u_br(cond_t cd, pc_t t);
    return u_mk(OP_BRANCH, 8'h00, SRC_ID, cd, FIN_NO, 1'b0, t);
  endfunction

  function automatic uword_t u_disp();
    return u_mk(OP_DISP, 8'h00, SRC_ID, C_NOFIRST, FIN_NO, 1'b0, '0);
  endfunction

  // Frame program. Common head: optional brace, '#', three address digits
  // (forced to 255 for broadcasts), 'P', then dispatch on the command.
  function automatic uword_t sacf_ucode(pc_t a);
    uword_t w;
    unique case (a)
      7'd0:  w = u_br(C_NOFIRST, 7'd2);
      7'd1:  w = u_chr(CH_LBRACE);
      7'd2:  w = u_chr(CH_HASH);
      7'd3:  w = u_load(SRC_ID);
      7'd4, 7'd5, 7'd6: w = u_conv();
      7'd7, 7'd8, 7'd9: w = u_dig();
      7'd10: w = u_chr("P");
      7'd11: w = u_disp();
      // position
      7'd12: w = u_load(SRC_PW);
      7'd13, 7'd14, 7'd15, 7'd16: w = u_conv();
      7'd17, 7'd18, 7'd19, 7'd20: w = u_dig();
      7'd21: w = u_chr("T");
      7'd22: w = u_load(SRC_TM);
      7'd23, 7'd24, 7'd25, 7'd26: w = u_conv();
      7'd27, 7'd28, 7'd29: w = u_dig();
      7'd30: w = u_digj(A_BANG_GRP);
      // torque release
      7'd31: w = u_chr("U");
      7'd32: w = u_chr("L");
      7'd33: w = u_chrj("K", A_BANG_GRP);
      // torque enable
      7'd34: w = u_chr("U");
      7'd35: w = u_chr("L");
      7'd36: w = u_chrj("R", A_BANG_GRP);
      // centre
      7'd37: w = u_chr("S");
      7'd38: w = u_chr("C");
      7'd39: w = u_chrj("K", A_BANG_CRLF);
      // mode broadcast
      7'd40: w = u_chr("M");
      7'd41: w = u_chr("O");
      7'd42: w = u_chr("D");
      7'd43: w = u_load(SRC_MODE8);
      7'd44: w = u_conv();
      7'd45: w = u_digj(A_BANG_CRLF);
      // force id
      7'd46: w = u_chr("I");
      7'd47: w = u_chr("D");
      7'd48: w = u_load(SRC_NADDR);
      7'd49, 7'd50, 7'd51: w = u_conv();
      7'd52, 7'd53: w = u_dig();
      7'd54: w = u_digj(A_BANG_CRLF);
      // boot mode, falls into the tail
      7'd55: w = u_chr("C");
      7'd56: w = u_chr("S");
      7'd57: w = u_chr("M");
      7'd58: w = u_load(SRC_MODE3);
      7'd59: w = u_conv();
      7'd60: w = u_dig();
      // tails
      7'd61: w = u_chr(CH_BANG);
      7'd62: w = u_chr(CH_CR);
      7'd63: w = u_chrf(CH_LF, FIN_YES);
      7'd64: w = u_chrf(CH_BANG, FIN_GRP);
      7'd65: w = u_br(C_NOGRP, A_CRLF);
      7'd66: w = u_chrj(CH_RBRACE, A_CRLF);
      default: w = u_chrf(CH_LF, FIN_YES);
    endcase
    return w;
  endfunction

  function automatic pc_t sacf_entry(logic [2:0] cmd);
    pc_t p;
    unique case (cmd)
      CMD_POS:  p = A_POS;
      CMD_REL:  p = A_REL;
      CMD_ENA:  p = A_ENA;
      CMD_CEN:  p = A_CEN;
      CMD_MODE: p = A_MOD;
      CMD_FID:  p = A_FID;
      default:  p = A_BOOT;
    endcase
    return p;
  endfunction

endpackage

// ----- design/sacf_digits.sv -----
module sacf_digits
  import sacf_pkg::*;
(
  input  logic     clk,
  input  dig_ctl_t ctl,
  input  val_t     load_val,
  output logic [3:0] digit
);

  val_t              conv_r;
  logic [3:0]        digits_r [DIG_N];
  logic [26:0]       prod;
  logic [10:0]       quot;
  val_t              tens;
  val_t              rem;

  // v/10 as (v*6554)>>16, exact for v below 10000
  assign prod = 27'(conv_r) * 27'd6554;
  assign quot = prod[26:16];
  assign tens = 14'({quot, 3'b000}) + 14'({quot, 1'b0});
  assign rem  = conv_r - tens;

  // digits enter at the top, least significant first; after the last
  // step the most significant digit sits on top and is read out by shifting
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      conv_r <= load_val;
    end else if (ctl.step) begin
      conv_r <= VAL_W'(quot);
      digits_r[DIG_N-1] <= rem[3:0];
      for (int i = 0; i < DIG_N-1; i++) begin
        digits_r[i] <= digits_r[i+1];
      end
    end else if (ctl.shift) begin
      digits_r[0] <= 4'd0;
      for (int i = 1; i < DIG_N; i++) begin
        digits_r[i] <= digits_r[i-1];
      end
    end
  end

  assign digit = digits_r[DIG_N-1];

endmodule

// ----- design/servo_ascii_command_framer_core.sv -----
// Throughput: one microcode step per cycle; a command is accepted and then runs its
//   frame program (grouped position with both braces is the longest); bytes leave at
//   most one per cycle, output stall holds the step.
// Blocked position commands and selector 7 are accepted and produce nothing.
// Reset (synchronous, rst_n low): sequencer idle, output empty, limits 500/2500, motion on.
module servo_ascii_command_framer_core
  import sacf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_cmd,
  input  logic [7:0]           in_servo_id,
  input  logic [15:0]          in_pulse_width,
  input  logic [15:0]          in_move_time,
  input  logic [7:0]           in_mode_value,
  input  logic [7:0]           in_new_address,
  input  logic                 in_grouped,
  input  logic                 in_group_first,
  input  logic                 in_group_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_frame_byte,
  output logic                 out_frame_end
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t      state_r;
  pc_t         pc_r;
  pc_t         pc_nxt;
  val_t        pulse_min_r;
  val_t        pulse_max_r;
  logic        motion_r;

  logic [2:0]  cmd_r;
  logic [7:0]  id_r;
  val_t        pw_r;
  val_t        tm_r;
  logic [7:0]  mode_r;
  logic [7:0]  naddr_r;
  logic        grp_r;
  logic        first_r;
  logic        last_r;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_end_r;

  uword_t      uw;
  dig_ctl_t    dctl;
  logic [3:0]  digit;
  val_t        load_val;
  logic        accept;
  logic        go;
  logic        emit;
  logic        out_free;
  logic        advance;
  logic        end_now;
  logic [7:0]  emit_byte;
  logic        cond_hit;
  logic        groupable;
  logic [15:0] pw_lo;
  logic [15:0] pw_hi;
  val_t        pw_clamp;
  val_t        tm_clamp;
  logic [3:0]  mode8;
  logic [1:0]  mode3;
  logic [7:0]  naddr_clamp;

  assign in_stall  = (state_r == ST_RUN);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign go        = (in_cmd <= CMD_BOOT) && !((in_cmd == CMD_POS) && !motion_r);
  assign groupable = (in_cmd <= CMD_ENA);

  // pulse: raise to min, lower to max, then cap at four digits
  assign pw_lo    = (in_pulse_width < 16'(pulse_min_r)) ? 16'(pulse_min_r) : in_pulse_width;
  assign pw_hi    = (pw_lo > 16'(pulse_max_r)) ? 16'(pulse_max_r) : pw_lo;
  assign pw_clamp = (pw_hi > 16'(DEC4_MAX)) ? DEC4_MAX : pw_hi[VAL_W-1:0];
  assign tm_clamp = (in_move_time > 16'(DEC4_MAX)) ? DEC4_MAX : in_move_time[VAL_W-1:0];

  assign mode8 = (mode_r == 8'd0) ? 4'd1 : (mode_r > 8'd8) ? 4'd8 : mode_r[3:0];
  assign mode3 = (mode_r == 8'd0) ? 2'd1 : (mode_r > 8'd3) ? 2'd3 : mode_r[1:0];
  assign naddr_clamp = (naddr_r > ADDR_MAX) ? ADDR_MAX : naddr_r;

  assign uw = sacf_ucode(pc_r);

  always_comb begin
    unique case (uw.src)
      SRC_ID:    load_val = ((cmd_r == CMD_MODE) || (cmd_r == CMD_FID)) ?
                            VAL_W'(ADDR_BCAST) : VAL_W'(id_r);
      SRC_PW:    load_val = pw_r;
      SRC_TM:    load_val = tm_r;
      SRC_MODE8: load_val = VAL_W'(mode8);
      SRC_MODE3: load_val = VAL_W'(mode3);
      SRC_NADDR: load_val = VAL_W'(naddr_clamp);
      default:   load_val = '0;
    endcase
  end

  assign emit      = (state_r == ST_RUN) && ((uw.op == OP_CHAR) || (uw.op == OP_DIGIT));
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = (state_r == ST_RUN) && (!emit || out_free);
  assign emit_byte = (uw.op == OP_CHAR) ? uw.chr : {ASCII_DIGIT_HI, digit};
  assign end_now   = (uw.fin == FIN_YES) || ((uw.fin == FIN_GRP) && grp_r && !last_r);
  assign cond_hit  = (uw.cond == C_NOFIRST) ? !first_r : !grp_r;

  assign dctl.load  = advance && (uw.op == OP_LOAD);
  assign dctl.step  = advance && (uw.op == OP_CONV);
  assign dctl.shift = advance && (uw.op == OP_DIGIT);

  always_comb begin
    unique case (uw.op)
      OP_BRANCH: pc_nxt = cond_hit ? uw.tgt : pc_r + 1'b1;
      OP_DISP:   pc_nxt = sacf_entry(cmd_r);
      default:   pc_nxt = uw.jmp ? uw.tgt : pc_r + 1'b1;
    endcase
  end

  sacf_digits u_digits (
    .clk      (clk),
    .ctl      (dctl),
    .load_val (load_val),
    .digit    (digit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_min_r <= PULSE_MIN_RST;
      pulse_max_r <= PULSE_MAX_RST;
      motion_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULSE_MIN: pulse_min_r <= cfg_wdata;
        CFG_PULSE_MAX: pulse_max_r <= cfg_wdata;
        CFG_MOTION:    motion_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit && out_free) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= emit_byte;
        out_end_r   <= end_now;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r   <= in_cmd;
            id_r    <= in_servo_id;
            pw_r    <= pw_clamp;
            tm_r    <= tm_clamp;
            mode_r  <= in_mode_value;
            naddr_r <= in_new_address;
            grp_r   <= groupable && in_grouped;
            first_r <= groupable && in_grouped && in_group_first;
            last_r  <= in_group_last;
            pc_r    <= '0;
            if (go) begin
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (advance) begin
            pc_r <= pc_nxt;
            if (emit && end_now) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_end  = out_end_r;

endmodule

// ----- tb/servo_ascii_command_framer_core_tb.sv -----
`timescale 1ns / 100ps

module servo_ascii_command_framer_core_tb;
  import sacf_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int DEC_LIMIT = 9999;
  localparam int LONG_HOLD = 400;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  id;
    logic [15:0] pw;
    logic [15:0] tm;
    logic [7:0]  mode;
    logic [7:0]  naddr;
    logic        grp;
    logic        first;
    logic        last;
  } servo_cmd_t;

  typedef struct packed {
    logic [7:0] code;
    logic       is_end;
  } frame_char_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_cmd = '0;
  logic [7:0]           in_servo_id = '0;
  logic [15:0]          in_pulse_width = '0;
  logic [15:0]          in_move_time = '0;
  logic [7:0]           in_mode_value = '0;
  logic [7:0]           in_new_address = '0;
  logic                 in_grouped = 1'b0;
  logic                 in_group_first = 1'b0;
  logic                 in_group_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_frame_byte;
  logic                 out_frame_end;

  servo_ascii_command_framer_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_servo_id    (in_servo_id),
    .in_pulse_width (in_pulse_width),
    .in_move_time   (in_move_time),
    .in_mode_value  (in_mode_value),
    .in_new_address (in_new_address),
    .in_grouped     (in_grouped),
    .in_group_first (in_group_first),
    .in_group_last  (in_group_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end)
  );

  always #6 clk = ~clk;

  // local copy of the limits and motion flag
  int unsigned lim_lo = PULSE_MIN_RST;
  int unsigned lim_hi = PULSE_MAX_RST;
  bit          motion_on = 1'b1;

  servo_cmd_t  cmd_backlog[$];
  frame_char_t frame_bytes_due[$];
  logic [7:0]  frame_buf[$];

  logic quiet = 1'b0;
  logic long_hold_go = 1'b0;
  int   mismatch_cnt = 0;

  function automatic void put_dec(int unsigned v, int n);
    int unsigned div;
    div = 1;
    for (int i = 1; i < n; i++) div = div * 10;
    for (int i = 0; i < n; i++) begin
      frame_buf.push_back(8'h30 + 8'((v / div) % 10));
      div = div / 10;
    end
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
  endfunction

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // renders the frame for one command and queues its bytes as due results
  function automatic void build_frame_bytes(servo_cmd_t c);
    int unsigned p;
    int unsigned t;
    bit groupable;
    frame_buf.delete();
    groupable = (c.cmd == CMD_POS) || (c.cmd == CMD_REL) || (c.cmd == CMD_ENA);
    if (c.cmd == CMD_UNUSED) return;
    if (c.cmd == CMD_POS && !motion_on) return;
    if (groupable && c.grp && c.first) frame_buf.push_back(CH_LBRACE);
    case (c.cmd)
      CMD_POS: begin
        p = c.pw;
        if (p < lim_lo) p = lim_lo;
        if (p > lim_hi) p = lim_hi;
        if (p > DEC_LIMIT) p = DEC_LIMIT;
        t = (c.tm > DEC_LIMIT) ? DEC_LIMIT : c.tm;
        frame_buf.push_back(CH_HASH);
        put_dec(c.id, 3);
        put_str("P");
        put_dec(p, 4);
        put_str("T");
        put_dec(t, 4);
        frame_buf.push_back(CH_BANG);
      end
      CMD_REL: begin
        frame_buf.push_back(CH_HASH);
        put_dec(c.id, 3);
        put_str("PULK!");
      end
      CMD_ENA: begin
        frame_buf.push_back(CH_HASH);
        put_dec(c.id, 3);
        put_str("PULR!");
      end
      CMD_CEN: begin
        frame_buf.push_back(CH_HASH);
        put_dec(c.id, 3);
        put_str("PSCK!");
      end
      CMD_MODE: begin
        put_str("#255PMOD");
        put_dec(clamp(c.mode, 1, 8), 1);
        frame_buf.push_back(CH_BANG);
      end
      CMD_FID: begin
        put_str("#255PID");
        put_dec((c.naddr > ADDR_MAX) ? ADDR_MAX : c.naddr, 3);
        frame_buf.push_back(CH_BANG);
      end
      default: begin
        frame_buf.push_back(CH_HASH);
        put_dec(c.id, 3);
        put_str("PCSM");
        put_dec(clamp(c.mode, 1, 3), 1);
        frame_buf.push_back(CH_BANG);
      end
    endcase
    if (groupable && c.grp) begin
      if (c.last) begin
        frame_buf.push_back(CH_RBRACE);
        frame_buf.push_back(CH_CR);
        frame_buf.push_back(CH_LF);
      end
    end else begin
      frame_buf.push_back(CH_CR);
      frame_buf.push_back(CH_LF);
    end
    for (int i = 0; i < frame_buf.size(); i++)
      frame_bytes_due.push_back('{frame_buf[i], i == frame_buf.size() - 1});
  endfunction

  // mostly short, now and then a long one
  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // ---------------- driver ----------------
  servo_cmd_t drv_cmd;
  int         gap_left = 0;
  bit         offering;
  bit         load_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      load_next = 1'b0;
      offering = in_valid;
      if (in_valid && !in_stall) begin
        build_frame_bytes(drv_cmd);
        offering = 1'b0;
        gap_left = (quiet || $urandom_range(0, 99) < 55) ? 0 : rand_len();
      end
      if (!offering) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
        end else if (cmd_backlog.size() != 0) begin
          drv_cmd = cmd_backlog.pop_front();
          offering = 1'b1;
          load_next = 1'b1;
        end
      end
      in_valid <= offering;
      if (load_next) begin
        in_cmd         <= drv_cmd.cmd;
        in_servo_id    <= drv_cmd.id;
        in_pulse_width <= drv_cmd.pw;
        in_move_time   <= drv_cmd.tm;
        in_mode_value  <= drv_cmd.mode;
        in_new_address <= drv_cmd.naddr;
        in_grouped     <= drv_cmd.grp;
        in_group_first <= drv_cmd.first;
        in_group_last  <= drv_cmd.last;
      end
    end
  end

  // ---------------- monitor ----------------
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  int          run_left = 0;
  bit          run_stall = 1'b0;
  bit          stall_nxt;
  frame_char_t due;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_bytes_due.size() == 0) begin
          $error("unexpected transfer: frame_byte 8'h%02h frame_end %0b",
                 out_frame_byte, out_frame_end);
          mismatch_cnt++;
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_frame_byte !== due.code) begin
            $error("frame_byte: expected 8'h%02h, got 8'h%02h", due.code, out_frame_byte);
            mismatch_cnt++;
          end
          if (out_frame_end !== due.is_end) begin
            $error("frame_end: expected %0b, got %0b", due.is_end, out_frame_end);
            mismatch_cnt++;
          end
        end
      end
      if (long_hold_go && !long_hold_done) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        stall_nxt = 1'b1;
      end else if (quiet) begin
        stall_nxt = 1'b0;
      end else if (run_left != 0) begin
        run_left = run_left - 1;
        stall_nxt = run_stall;
      end else begin
        run_stall = ($urandom_range(0, 2) == 0);
        run_left = run_stall ? rand_len() : $urandom_range(0, 6);
        stall_nxt = run_stall;
      end
      out_stall <= stall_nxt;
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("** servo_ascii_command_framer_core: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic servo_cmd_t mk_cmd(logic [2:0] op, logic [7:0] id, logic [15:0] pw,
                                        logic [15:0] tm, logic [7:0] mode, logic [7:0] naddr,
                                        logic g, logic f, logic l);
    return '{op, id, pw, tm, mode, naddr, g, f, l};
  endfunction

  function automatic servo_cmd_t rand_cmd();
    servo_cmd_t c;
    c.cmd = ($urandom_range(0, 19) == 0) ? CMD_UNUSED : 3'($urandom_range(0, 6));
    c.id = 8'($urandom);
    case ($urandom_range(0, 2))
      0:       c.pw = 16'($urandom);
      1:       c.pw = 16'($urandom_range(0, 10500));
      default: c.pw = 16'($urandom_range(400, 2600));
    endcase
    case ($urandom_range(0, 2))
      0:       c.tm = 16'($urandom);
      1:       c.tm = 16'($urandom_range(0, 10500));
      default: c.tm = 16'($urandom_range(9990, 10010));
    endcase
    c.mode = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10));
    c.naddr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(250, 255)) : 8'($urandom);
    c.grp = 1'($urandom);
    c.first = 1'($urandom);
    c.last = 1'($urandom);
    return c;
  endfunction

  // mostly well-formed brace groups and single commands, some broken groups
  task automatic queue_mix(int n);
    servo_cmd_t c;
    int k;
    int len;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 99) < 45) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          c = rand_cmd();
          c.cmd = 3'($urandom_range(0, 2));
          c.grp = 1'b1;
          c.first = (i == 0);
          c.last = (i == len - 1);
          if ($urandom_range(0, 9) == 0) begin
            c.first = 1'($urandom);
            c.last = 1'($urandom);
          end
          cmd_backlog.push_back(c);
        end
        k += len;
      end else begin
        cmd_backlog.push_back(rand_cmd());
        k++;
      end
    end
  endtask

  task automatic wait_drained();
    // check between edges so the driver's pop and its valid update are both visible
    while (cmd_backlog.size() != 0 || in_valid || frame_bytes_due.size() != 0)
      @(negedge clk);
    // blocked or unused commands produce nothing and never enter the run state
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    case (idx)
      CFG_PULSE_MIN: lim_lo = val & 14'h3FFF;
      CFG_PULSE_MAX: lim_hi = val & 14'h3FFF;
      CFG_MOTION:    motion_on = val[0];
      default: ;
    endcase
  endtask

  task automatic run_phase(int unsigned lo, int unsigned hi, bit mv, bit calm, int n,
                           bit hold);
    write_reg(CFG_PULSE_MIN, lo);
    write_reg(CFG_PULSE_MAX, hi);
    write_reg(CFG_MOTION, mv);
    cfg_we <= 1'b0;
    quiet <= calm;
    queue_mix(n);
    if (hold) long_hold_go <= 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every command, grouping and clamp corners
    cmd_backlog.push_back(mk_cmd(CMD_POS, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_POS, 8'd255, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_POS, 8'd7, 16'd1500, 16'd9999, 8'd0, 8'd0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_POS, 8'd42, 16'd2501, 16'd10000, 8'd0, 8'd0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_REL, 8'd12, 16'd0, 16'd0, 8'd0, 8'd0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_ENA, 8'd200, 16'd0, 16'd0, 8'd0, 8'd0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_POS, 8'd1, 16'd800, 16'd20, 8'd0, 8'd0, 1, 1, 0));
    cmd_backlog.push_back(mk_cmd(CMD_REL, 8'd2, 16'd0, 16'd0, 8'd0, 8'd0, 1, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_ENA, 8'd3, 16'd0, 16'd0, 8'd0, 8'd0, 1, 0, 1));
    cmd_backlog.push_back(mk_cmd(CMD_POS, 8'd99, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 1, 1, 1));
    cmd_backlog.push_back(mk_cmd(CMD_REL, 8'd5, 16'd0, 16'd0, 8'd0, 8'd0, 0, 1, 1));
    cmd_backlog.push_back(mk_cmd(CMD_CEN, 8'd255, 16'd0, 16'd0, 8'd0, 8'd0, 1, 1, 1));
    cmd_backlog.push_back(mk_cmd(CMD_MODE, 8'd9, 16'd0, 16'd0, 8'd0, 8'd0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_MODE, 8'd0, 16'd0, 16'd0, 8'd8, 8'd0, 1, 1, 1));
    cmd_backlog.push_back(mk_cmd(CMD_MODE, 8'd0, 16'd0, 16'd0, 8'd9, 8'd0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_MODE, 8'd0, 16'd0, 16'd0, 8'hFF, 8'd0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_FID, 8'd0, 16'd0, 16'd0, 8'd0, 8'd254, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_FID, 8'd0, 16'd0, 16'd0, 8'd0, 8'd255, 1, 1, 1));
    cmd_backlog.push_back(mk_cmd(CMD_FID, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_BOOT, 8'd17, 16'd0, 16'd0, 8'd0, 8'd0, 1, 1, 0));
    cmd_backlog.push_back(mk_cmd(CMD_BOOT, 8'd255, 16'd0, 16'd0, 8'd3, 8'd0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(CMD_BOOT, 8'd128, 16'd0, 16'd0, 8'hFF, 8'd0, 0, 0, 1));
    cmd_backlog.push_back(mk_cmd(CMD_UNUSED, 8'd1, 16'd1000, 16'd1, 8'd1, 8'd1, 1, 1, 1));
    cmd_backlog.push_back(mk_cmd(CMD_ENA, 8'd64, 16'd0, 16'd0, 8'd0, 8'd0, 1, 0, 0));
    wait_drained();

    run_phase(0, 9999, 1'b1, 1'b0, 60, 1'b0);
    // crossed limits: upper limit wins
    run_phase(3000, 1000, 1'b1, 1'b0, 40, 1'b0);
    run_phase(500, 2500, 1'b0, 1'b0, 40, 1'b0);
    // upper limit beyond four digits; sender keeps offering through a long output hold
    run_phase(0, 16383, 1'b1, 1'b1, 60, 1'b1);
    run_phase(9999, 9999, 1'b1, 1'b0, 30, 1'b0);
    run_phase($urandom_range(0, 9999), $urandom_range(0, 9999), 1'b1, 1'b0, 60, 1'b0);
    run_phase($urandom_range(0, 9999), $urandom_range(0, 9999), 1'($urandom), 1'($urandom),
              50, 1'b0);

    repeat (32) @(posedge clk);
    if (mismatch_cnt == 0 && frame_bytes_due.size() == 0) begin
      $display("** servo_ascii_command_framer_core: PASSED **");
    end else begin
      $display("** servo_ascii_command_framer_core: FAILED **");
    end
    $finish;
  end

endmodule
